FILE: rtl/recursive_median_filter_defines.svh
// Assertion macros shared by the checker of the recursive median filter.
`ifndef RECURSIVE_MEDIAN_FILTER_DEFINES_SVH
`define RECURSIVE_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication.
`define RMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("recursive_median_filter: check failed");

// Next-cycle implication.
`define RMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("recursive_median_filter: check failed");

`endif

FILE: rtl/rmf_pkg.sv
// Package of constants and types for the recursive median filter.
`timescale 1ns / 1ps

package rmf_pkg;

   localparam int MAX_WINDOW   = 15;
   localparam int SAMPLE_BITS  = 24;
   localparam int CFG_W        = 8;
   localparam int CFG_RESET    = 5;
   localparam int BYPASS_LIMIT = 3;

   localparam int HIST_DEPTH = MAX_WINDOW / 2;
   localparam int PEND_DEPTH = MAX_WINDOW - MAX_WINDOW / 2;

   localparam int WIN_IDX_W  = $clog2(MAX_WINDOW);
   localparam int WIN_CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W      = WIN_CNT_W + 1;
   localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int PEND_IDX_W = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
   localparam int PEND_CNT_W = $clog2(PEND_DEPTH + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type window_type [MAX_WINDOW];

endpackage

FILE: rtl/recursive_median_filter.sv
// Top level of the recursive median filter with its sequencer and storage.
//
// Usage:
//   req_* carries one 24-bit signed sample and its block-end flag per transfer
//   (valid/stall). rsp_* returns filtered samples, oldest first, with
//   rsp_block_last on the result of a block's last sample. csr_* writes the
//   window length; csr_ready is always high, write only while idle.
//   A sample is held until the lookahead of the window has arrived; a
//   block-end sample flushes all held samples, so one transfer in gives zero
//   to eight transfers out.
//   Each median passes through a check, a window load, the rank step and
//   an emit; the rank step is set by the single rank unit that tests one
//   candidate entry per cycle. A bypass result goes from the check straight
//   to the emit. An item with no result frees the input after its check.
//   req_stall is high from the cycle after a transfer through the check step
//   after its last result enters the output register. If rsp_stall holds the
//   output register, the sequencer waits in its emit step.
//   Reset (synchronous, active high) clears the history to zero, empties the
//   held samples, drops any pending result and sets the window length to 5.
`timescale 1ns / 1ps

module recursive_median_filter
   import rmf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                   req_block_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                   rsp_block_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_window_size
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_RANK,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      window_size_ff, window_size_in;
   logic [PEND_CNT_W-1:0] count_ff, count_in;
   sample_type            pend_ff [PEND_DEPTH];
   sample_type            pend_in [PEND_DEPTH];
   sample_type            hist_ff [HIST_DEPTH];
   sample_type            hist_in [HIST_DEPTH];
   window_type            win_ff, win_in, win_load;
   logic [WIN_IDX_W-1:0]  idx_ff, idx_in;
   logic                  be_ff, be_in;
   sample_type            res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_sample_ff, rsp_sample_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  bypass;
   logic [WIN_CNT_W-1:0]  win_eff;
   logic [WIN_CNT_W-1:0]  half;
   logic [WIN_CNT_W-1:0]  look;
   logic                  out_free;
   logic                  hit;

   assign bypass  = window_size_ff < CFG_W'(BYPASS_LIMIT);
   assign win_eff = (window_size_ff > CFG_W'(MAX_WINDOW)) ? WIN_CNT_W'(MAX_WINDOW)
                                                          : window_size_ff[WIN_CNT_W-1:0];
   assign half    = win_eff >> 1;
   assign look    = win_eff - half - WIN_CNT_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_block_last = rsp_last_ff;
   assign csr_ready      = 1'b1;

   rmf_rank u_rank (
      .win       (win_ff),
      .cand_idx  (idx_ff),
      .win_count (win_eff),
      .half      (half),
      .hit       (hit)
   );

   always_comb begin
      int hidx;
      int pidx;
      hidx = 0;
      pidx = 0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (WIN_CNT_W'(k) < half) begin
            hidx = HIST_DEPTH - int'(half) + k;
            win_load[k] = hist_ff[HIST_IDX_W'(hidx)];
         end else begin
            pidx = k - int'(half);
            if (pidx >= int'(count_ff)) begin
               pidx = int'(count_ff) - 1;
            end
            win_load[k] = pend_ff[PEND_IDX_W'(pidx)];
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      window_size_in = window_size_ff;
      count_in       = count_ff;
      pend_in        = pend_ff;
      hist_in        = hist_ff;
      win_in         = win_ff;
      idx_in         = idx_ff;
      be_in          = be_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid) begin
         window_size_in = csr_window_size;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_in[count_ff[PEND_IDX_W-1:0]] = req_sample_in;
               count_in = count_ff + 1'b1;
               be_in    = req_block_end;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end else if (bypass) begin
               res_in   = pend_ff[0];
               state_in = ST_EMIT;
            end else if (be_ff || (CMP_W'(count_ff) > CMP_W'(look))) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            win_in   = win_load;
            idx_in   = '0;
            state_in = ST_RANK;
         end
         ST_RANK: begin
            if (hit) begin
               res_in   = win_ff[idx_ff];
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_last_in   = be_ff && (count_ff == PEND_CNT_W'(1));
               for (int j = 0; j < PEND_DEPTH - 1; j++) begin
                  pend_in[j] = pend_ff[j+1];
               end
               count_in = count_ff - 1'b1;
               if (!bypass) begin
                  for (int j = 0; j < HIST_DEPTH - 1; j++) begin
                     hist_in[j] = hist_ff[j+1];
                  end
                  hist_in[HIST_DEPTH-1] = res_ff;
               end
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= CFG_W'(CFG_RESET);
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int j = 0; j < HIST_DEPTH; j++) begin
            hist_ff[j] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         hist_ff        <= hist_in;
      end
      pend_ff       <= pend_in;
      win_ff        <= win_in;
      idx_ff        <= idx_in;
      be_ff         <= be_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

FILE: rtl/rmf_rank.sv
// Rank unit: tests whether one window entry sits at the median position.
`timescale 1ns / 1ps

module rmf_rank
   import rmf_pkg::*;
(
   input  window_type             win,
   input  logic [WIN_IDX_W-1:0]   cand_idx,
   input  logic [WIN_CNT_W-1:0]   win_count,
   input  logic [WIN_CNT_W-1:0]   half,
   output logic                   hit
);

   sample_type           cand;
   logic [WIN_CNT_W-1:0] less_cnt;
   logic [WIN_CNT_W-1:0] leq_cnt;

   assign cand = win[cand_idx];

   always_comb begin
      less_cnt = '0;
      leq_cnt  = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         if (WIN_CNT_W'(j) < win_count) begin
            if (win[j] < cand) begin
               less_cnt = less_cnt + 1'b1;
            end
            if (win[j] <= cand) begin
               leq_cnt = leq_cnt + 1'b1;
            end
         end
      end
   end

   assign hit = (less_cnt <= half) && (leq_cnt > half);

endmodule

FILE: rtl/rmf_checker.sv
// Port-level checker for the recursive median filter and its bind.
`timescale 1ns / 1ps
`include "recursive_median_filter_defines.svh"

module rmf_checker
   import rmf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [SAMPLE_BITS-1:0] req_sample_in,
   input logic                   req_block_end,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                   rsp_block_last,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CFG_W-1:0]       csr_window_size
);

   // Stalled result holds.
   `RMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_block_last))

   // An accepted sample keeps the input stalled next cycle.
   `RMF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // A new result only comes from a busy sequencer.
   `RMF_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // The register port never pushes back.
   `RMF_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind recursive_median_filter rmf_checker u_rmf_checker (.*);
